// ===== src/cld_pkg.sv =====
// ----------------------------------------------------------------------------
// cld_pkg
// shared codes and types of the cached lock directory
// ----------------------------------------------------------------------------
package cld_pkg;

	localparam int STATUS_W = 2;
	localparam int KIND_W   = 2;

	typedef enum logic {
		CMD_ACQUIRE = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		LK_FREE      = 2'd0,
		LK_LOCKED    = 2'd1,
		LK_REVOKING  = 2'd2,
		LK_RETRYING  = 2'd3
	} lock_st_t;

	typedef enum logic [STATUS_W-1:0] {
		RSP_OK    = 2'd0,
		RSP_RETRY = 2'd1,
		RSP_ERROR = 2'd2
	} rsp_t;

	typedef enum logic [KIND_W-1:0] {
		MSG_NONE   = 2'd0,
		MSG_REVOKE = 2'd1,
		MSG_RETRY  = 2'd2
	} msg_t;

	typedef enum logic {
		PH_CLEAR = 1'b0,
		PH_RUN   = 1'b1
	} phase_t;

endpackage

// ===== src/cld_ram.sv =====
// ----------------------------------------------------------------------------
// cld_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module cld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/cached_lock_directory.sv =====
// ----------------------------------------------------------------------------
// cached_lock_directory
// lock table with acquire and release, revoke and retry callbacks
// ----------------------------------------------------------------------------
// A request transfer (cmd, lock_index, client) is taken at every rising edge
// where start is high and busy is low, one per cycle if wanted. Its single
// reply appears on status and the message ports for one cycle, flagged by
// done, from the result register that follows the request register. The
// sustained rate is one request per cycle while busy is low. The table
// ram shapes the pipeline: its registered read feeds one pass of check and
// update logic that writes the entry back the next edge, and a one-entry
// bypass covers a request to the lock written just before. Results cannot
// be held off by the receiver. After reset busy stays high while a clearing
// pass walks the table one entry per cycle, setting every lock free.
module cached_lock_directory
	import cld_pkg::*;
#(
	parameter int NUM_LOCKS   = 64,
	parameter int NUM_CLIENTS = 16,
	localparam int IDX_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1,
	localparam int CL_W  = $clog2(NUM_CLIENTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  logic [IDX_W-1:0]    lock_index,
	input  logic [CL_W-1:0]     client,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [KIND_W-1:0]   message_kind,
	output logic [CL_W-1:0]     message_target,
	output logic [IDX_W-1:0]    message_lock
);

	// one table entry
	typedef struct packed {
		lock_st_t               st;
		logic [CL_W-1:0]        owner;
		logic [CL_W-1:0]        retry;
		logic [NUM_CLIENTS-1:0] mask;
	} entry_t;

	localparam int EW = $bits(entry_t);
	localparam logic [IDX_W:0] NLOCK_L = NUM_LOCKS[IDX_W:0];
	localparam logic [CL_W:0]  NCL_L   = NUM_CLIENTS[CL_W:0];
	localparam logic [IDX_W-1:0] LAST_L = IDX_W'(NUM_LOCKS - 1);

	// lowest set bit of the waiting mask
	function automatic logic [CL_W-1:0] lowest_waiter(input logic [NUM_CLIENTS-1:0] m);
		logic [CL_W-1:0] r;
		r = '0;
		for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CL_W'(i);
			end
		end
		return r;
	endfunction

	// clearing pass control
	phase_t          phase_q, phase_d;
	logic [IDX_W-1:0] clr_q, clr_d;

	// stage 1: request registered alongside the ram read
	logic             vld_s1;
	cmd_t             cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CL_W-1:0]  cl_s1;

	// bypass of the write made at the previous edge
	logic             byp_vld_q;
	logic [IDX_W-1:0] byp_idx_q;
	entry_t           byp_ent_q;

	// table ram ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic [EW-1:0]    ram_rdata;

	// stage 1 logic
	entry_t           cur, nxt;
	logic             err;
	logic             in_range;
	logic [NUM_CLIENTS-1:0] cbit;
	logic [CL_W-1:0]  nxt_waiter;
	rsp_t             rsp_d;
	msg_t             kind_d;
	logic [CL_W-1:0]  tgt_d;

	logic accept;

	assign busy   = (phase_q == PH_CLEAR);
	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// clearing pass after reset
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLEAR;
			clr_q   <= '0;
		end else begin
			phase_q <= phase_d;
			clr_q   <= clr_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		clr_d   = clr_q;
		case (phase_q)
			PH_CLEAR: begin
				clr_d = clr_q + 1'b1;
				if (clr_q == LAST_L) begin
					phase_d = PH_RUN;
					clr_d   = '0;
				end
			end
			PH_RUN: begin
				clr_d = '0;
			end
			default: begin
				phase_d = PH_CLEAR;
				clr_d   = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// table
	// ------------------------------------------------------------------
	cld_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_LOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (lock_index),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (busy) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = vld_s1 && !err;
			ram_waddr = idx_s1;
			ram_wdata = nxt;
		end
	end

	// ------------------------------------------------------------------
	// request register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			vld_s1    <= accept;
			byp_vld_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_t'(cmd);
			idx_s1 <= lock_index;
			cl_s1  <= client;
		end
		byp_idx_q <= ram_waddr;
		byp_ent_q <= ram_wdata;
	end

	// ------------------------------------------------------------------
	// check and update of the addressed entry
	// ------------------------------------------------------------------
	always_comb begin
		// the ram read misses a write made at the same edge
		if (byp_vld_q && (byp_idx_q == idx_s1)) begin
			cur = byp_ent_q;
		end else begin
			cur = entry_t'(ram_rdata);
		end

		in_range   = ({1'b0, idx_s1} < NLOCK_L) && ({1'b0, cl_s1} < NCL_L);
		cbit       = {{(NUM_CLIENTS-1){1'b0}}, 1'b1} << cl_s1;
		nxt_waiter = lowest_waiter(cur.mask);

		nxt    = cur;
		err    = 1'b1;
		rsp_d  = RSP_ERROR;
		kind_d = MSG_NONE;
		tgt_d  = '0;

		if (in_range) begin
			if (cmd_s1 == CMD_ACQUIRE) begin
				case (cur.st)
					LK_FREE: begin
						err       = 1'b0;
						rsp_d     = RSP_OK;
						nxt.st    = LK_LOCKED;
						nxt.owner = cl_s1;
					end
					LK_LOCKED: begin
						if (((cur.mask & cbit) == '0) && (cur.owner != cl_s1)) begin
							// first contention: queue and revoke the holder
							err      = 1'b0;
							rsp_d    = RSP_RETRY;
							kind_d   = MSG_REVOKE;
							tgt_d    = cur.owner;
							nxt.mask = cur.mask | cbit;
							nxt.st   = LK_REVOKING;
						end
					end
					LK_REVOKING: begin
						// owner asking again is queued like anyone else
						if ((cur.mask & cbit) == '0) begin
							err      = 1'b0;
							rsp_d    = RSP_RETRY;
							nxt.mask = cur.mask | cbit;
						end
					end
					LK_RETRYING: begin
						if ((cur.mask & cbit) == '0) begin
							err = 1'b0;
							if (cur.retry == cl_s1) begin
								// the client told to retry takes the lock
								rsp_d     = RSP_OK;
								nxt.owner = cl_s1;
								nxt.retry = '0;
								if (cur.mask != '0) begin
									nxt.st = LK_REVOKING;
									kind_d = MSG_REVOKE;
									tgt_d  = cl_s1;
								end else begin
									nxt.st = LK_LOCKED;
								end
							end else begin
								rsp_d    = RSP_RETRY;
								nxt.mask = cur.mask | cbit;
							end
						end
					end
					default: begin
						err = 1'b1;
					end
				endcase
			end else begin
				// release by the owner of a revoking lock hands it on
				if ((cur.st == LK_REVOKING) && (cur.owner == cl_s1) && (cur.mask != '0)) begin
					err       = 1'b0;
					rsp_d     = RSP_OK;
					kind_d    = MSG_RETRY;
					tgt_d     = nxt_waiter;
					nxt.mask  = cur.mask & ~({{(NUM_CLIENTS-1){1'b0}}, 1'b1} << nxt_waiter);
					nxt.retry = nxt_waiter;
					nxt.owner = '0;
					nxt.st    = LK_RETRYING;
				end
			end
		end

		if (err) begin
			nxt = cur;
		end
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		status         <= rsp_d;
		message_kind   <= kind_d;
		message_target <= (kind_d == MSG_NONE) ? '0 : tgt_d;
		message_lock   <= (kind_d == MSG_NONE) ? '0 : idx_s1;
	end

`ifndef SYNTH
	// every request transfer is followed by its reply
	a_reply_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("reply missing after request");

	// no reply without an earlier request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("reply without request");

	// a failed check carries no callback
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == RSP_ERROR)) |->
		((message_kind == MSG_NONE) && (message_target == '0) && (message_lock == '0)))
		else $error("error reply with a callback");

	// a retry callback only ever goes with a successful release
	a_retry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (message_kind == MSG_RETRY)) |-> (status == RSP_OK))
		else $error("retry callback on a failed release");

	// nothing leaves the block during the clearing pass
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !done)
		else $error("reply during clearing pass");
`endif

endmodule
